// ===== rtl/event_timestamp_civil_converter_top_macros.svh =====
// Assertion macros for the event timestamp / civil date converter.
// Used by modules that check their own pipeline control; needs clk and arst_n in scope.
`ifndef EVENT_TIMESTAMP_CIVIL_CONVERTER_TOP_MACROS_SVH
`define EVENT_TIMESTAMP_CIVIL_CONVERTER_TOP_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ETCC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Antecedent at one edge, consequent at the next.
`define ETCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) \
		else $error(msg);

`endif

// ===== rtl/etcc_pkg.sv =====
// Shared constants, types and tables for the timestamp / civil date converter.
// No dependencies.
`default_nettype none

package etcc_pkg;

	localparam int NST = 9;

	// Day numbers relative to 0000-03-01; 1977-01-01 lands at BASE_DAYS.
	localparam int unsigned BASE_DAYS   = 722025;
	localparam int unsigned ERA_DAYS    = 146097;
	localparam int unsigned ERA_YEARS   = 400;
	// For stamps after the base: day count where era 5 starts, and doe offset in era 4.
	localparam int unsigned ERA5_START  = 8460;
	localparam int unsigned ERA4_OFS    = 137637;
	localparam int unsigned HALFDAY_SECS = 43200;
	localparam int unsigned FULL_DAY    = 86400;

	// Reciprocal multipliers: q = (x * M) >> K is exact over the operand width used.
	localparam int D400_K = 21;
	localparam logic [12:0] D400_M = 13'(((64'd1 << D400_K) + 64'd399) / 64'd400);
	localparam int D100_K = 16;
	localparam logic [9:0] D100_M = 10'(((64'd1 << D100_K) + 64'd99) / 64'd100);
	localparam int D1460_K = 29;
	localparam logic [18:0] D1460_M = 19'(((64'd1 << D1460_K) + 64'd1459) / 64'd1460);
	localparam int D36524_K = 34;
	localparam logic [18:0] D36524_M = 19'(((64'd1 << D36524_K) + 64'd36523) / 64'd36524);
	localparam int D365_K = 27;
	localparam logic [18:0] D365_M = 19'(((64'd1 << D365_K) + 64'd364) / 64'd365);
	localparam int D153_K = 19;
	localparam logic [11:0] D153_M = 12'(((64'd1 << D153_K) + 64'd152) / 64'd153);
	// (5*doy + 2) * M folded into doy * M5 + M2
	localparam logic [14:0] D153_M5 = 15'(64'd5 * 64'(D153_M));
	localparam logic [12:0] D153_M2 = 13'(64'd2 * 64'(D153_M));
	localparam int D3600_K = 29;
	localparam logic [17:0] D3600_M = 18'(((64'd1 << D3600_K) + 64'd3599) / 64'd3600);
	localparam int D60_K = 18;
	localparam logic [12:0] D60_M = 13'(((64'd1 << D60_K) + 64'd59) / 64'd60);

	// Conversion direction carried in the request transaction.
	typedef enum logic {
		OP_TO_STAMP = 1'b0,
		OP_TO_CIVIL = 1'b1
	} conv_op_t;

	typedef struct packed {
		logic [NST-1:0] en;
		logic [NST-1:0] vld;
	} pipe_ctrl_t;

	// Days before the start of month index mp (March-based year).
	function automatic logic [8:0] month_off(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			4'd12:   r = 9'd367;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/etcc_if.sv =====
// Request and response stream interfaces of the timestamp / civil date converter.
// No dependencies.
`default_nettype none

interface etcc_cmd_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic [15:0] halfday_in;
	logic [15:0] seconds_in;

	modport source (output valid, op, year, month, day, hour, minute, second,
		halfday_in, seconds_in, input ready);
	modport sink (input valid, op, year, month, day, hour, minute, second,
		halfday_in, seconds_in, output ready);
endinterface

interface etcc_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] halfday_out;
	logic [15:0] seconds_out;
	logic [11:0] year_out;
	logic [3:0]  month_out;
	logic [4:0]  day_out;
	logic [4:0]  hour_out;
	logic [5:0]  minute_out;
	logic [5:0]  second_out;
	logic        out_of_range;

	modport source (output valid, halfday_out, seconds_out, year_out, month_out, day_out,
		hour_out, minute_out, second_out, out_of_range, input ready);
	modport sink (input valid, halfday_out, seconds_out, year_out, month_out, day_out,
		hour_out, minute_out, second_out, out_of_range, output ready);
endinterface

`default_nettype wire

// ===== rtl/etcc_ctrl.sv =====
// Pipeline valid bits and per-stage load enables for the converter.
// Depends on etcc_pkg and the assertion macro header.
`default_nettype none
`include "event_timestamp_civil_converter_top_macros.svh"

module etcc_ctrl import etcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       out_ready,
	output logic       in_ready,
	output pipe_ctrl_t ctl
);

	logic [NST-1:0] vld_q;
	logic [NST-1:0] en;

	// A stage loads when it is empty or its content moves on; bubbles collapse.
	always_comb begin
		en[NST-1] = !vld_q[NST-1] || out_ready;
		for (int k = NST-2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready = en[0];
	assign ctl.en   = en;
	assign ctl.vld  = vld_q;

	`ETCC_ASSERT(a_stall_only_full, (~en & ~vld_q) == '0, "empty stage held back")
	`ETCC_ASSERT_NEXT(a_accept_fills_s1, arst_n && in_valid && en[0], vld_q[0], "accepted transaction missing in first stage")
	`ETCC_ASSERT_NEXT(a_stall_holds, arst_n && vld_q[0] && !en[1], vld_q[0], "stalled stage dropped its transaction")
	`ETCC_ASSERT_NEXT(a_count, arst_n, $countones(vld_q) == $past($countones(vld_q)) + ($past(in_valid && en[0]) ? 1 : 0) - ($past(vld_q[NST-1] && out_ready) ? 1 : 0), "transactions created or lost in pipeline")

endmodule

`default_nettype wire

// ===== rtl/etcc_to_stamp.sv =====
// Civil date and time to half-day stamp datapath (op 0), nine register stages.
// Depends on etcc_pkg; stage enables come from etcc_ctrl.
`default_nettype none

module etcc_to_stamp import etcc_pkg::*; (
	input  logic        clk,
	input  pipe_ctrl_t  ctl,
	input  logic        op,
	input  logic [11:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic [5:0]  second,
	output logic [15:0] halfday_out,
	output logic [15:0] seconds_out,
	output logic        out_of_range
);

	// stage 1: year shift for Jan/Feb, month index, day of year, second of day, era product
	logic        dec_c, yneg_c;
	logic [11:0] ya_c;
	logic [3:0]  mp_c;
	logic signed [10:0] doy_c;
	logic [16:0] sod_c;
	logic [24:0] pa_c;

	logic        act_s1, yneg_s1;
	logic [11:0] ya_s1;
	logic signed [10:0] doy_s1;
	logic [16:0] sod_s1;
	logic [24:0] pa_s1;

	always_comb begin
		dec_c  = month <= 4'd2;
		yneg_c = dec_c && (year == 12'd0);
		ya_c   = year - {11'b0, dec_c};
		mp_c   = dec_c ? month + 4'd9 : month - 4'd3;
		doy_c  = $signed({2'b0, month_off(mp_c)}) + $signed({6'b0, day}) - 11'sd1;
		sod_c  = {12'b0, hour} * 17'd3600 + {11'b0, minute} * 17'd60 + {11'b0, second};
		pa_c   = {13'b0, ya_c} * {12'b0, D400_M};
	end

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			act_s1  <= (op == OP_TO_STAMP);
			yneg_s1 <= yneg_c;
			ya_s1   <= ya_c;
			doy_s1  <= doy_c;
			sod_s1  <= sod_c;
			pa_s1   <= pa_c;
		end
	end

	// stage 2: era and year of era, half-day split of the second of day
	logic [3:0]  eq_c;
	logic [11:0] ydiff_c;
	logic signed [4:0] era_c;
	logic [8:0]  yoe_c;
	logic [1:0]  q_c;
	logic [16:0] srem_c;

	logic        act_s2;
	logic signed [4:0] era_s2;
	logic [8:0]  yoe_s2;
	logic signed [10:0] doy_s2;
	logic [1:0]  q_s2;
	logic [15:0] srem_s2;

	always_comb begin
		eq_c    = pa_s1[D400_K+3:D400_K];
		ydiff_c = ya_s1 - {8'b0, eq_c} * 12'(ERA_YEARS);
		era_c   = yneg_s1 ? -5'sd1 : $signed({1'b0, eq_c});
		yoe_c   = yneg_s1 ? 9'd399 : ydiff_c[8:0];
		if (sod_s1 >= 17'(FULL_DAY)) begin
			q_c    = 2'd2;
			srem_c = sod_s1 - 17'(FULL_DAY);
		end else if (sod_s1 >= 17'(HALFDAY_SECS)) begin
			q_c    = 2'd1;
			srem_c = sod_s1 - 17'(HALFDAY_SECS);
		end else begin
			q_c    = 2'd0;
			srem_c = sod_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			act_s2  <= act_s1;
			era_s2  <= era_c;
			yoe_s2  <= yoe_c;
			doy_s2  <= doy_s1;
			q_s2    <= q_c;
			srem_s2 <= srem_c[15:0];
		end
	end

	// stage 3: constant products of era and year of era
	logic [18:0] p100_c;
	logic [17:0] y365_c;
	logic signed [22:0] e146_c;

	logic        act_s3;
	logic signed [22:0] e146_s3;
	logic [17:0] y365_s3;
	logic [6:0]  y4_s3;
	logic [1:0]  y100_s3;
	logic signed [10:0] doy_s3;
	logic [1:0]  q_s3;
	logic [15:0] srem_s3;

	always_comb begin
		p100_c = {10'b0, yoe_s2} * {9'b0, D100_M};
		y365_c = {9'b0, yoe_s2} * 18'd365;
		e146_c = $signed({{18{era_s2[4]}}, era_s2}) * $signed(23'(ERA_DAYS));
	end

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			act_s3  <= act_s2;
			e146_s3 <= e146_c;
			y365_s3 <= y365_c;
			y4_s3   <= yoe_s2[8:2];
			y100_s3 <= p100_c[D100_K+1:D100_K];
			doy_s3  <= doy_s2;
			q_s3    <= q_s2;
			srem_s3 <= srem_s2;
		end
	end

	// stage 4: day of era and era base
	logic signed [23:0] doe_c, ebase_c;

	logic        act_s4;
	logic signed [23:0] doe_s4, ebase_s4;
	logic [1:0]  q_s4;
	logic [15:0] srem_s4;

	always_comb begin
		doe_c   = $signed({6'b0, y365_s3}) + $signed({17'b0, y4_s3})
			- $signed({22'b0, y100_s3}) + $signed({{13{doy_s3[10]}}, doy_s3});
		ebase_c = $signed({e146_s3[22], e146_s3}) - $signed(24'(BASE_DAYS));
	end

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			act_s4   <= act_s3;
			doe_s4   <= doe_c;
			ebase_s4 <= ebase_c;
			q_s4     <= q_s3;
			srem_s4  <= srem_s3;
		end
	end

	// stage 5: days since the base
	logic        act_s5;
	logic signed [23:0] days_s5;
	logic [1:0]  q_s5;
	logic [15:0] srem_s5;

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			act_s5  <= act_s4;
			days_s5 <= ebase_s4 + doe_s4;
			q_s5    <= q_s4;
			srem_s5 <= srem_s4;
		end
	end

	// stage 6: half-day count and range flag
	logic signed [24:0] hd_c;
	logic        oor_c;

	logic        act_s6, oor_s6;
	logic [15:0] hd_s6, srem_s6;

	always_comb begin
		hd_c  = $signed({days_s5, 1'b0}) + $signed({23'b0, q_s5});
		oor_c = days_s5[23] || (|hd_c[23:16]);
	end

	always_ff @(posedge clk) begin
		if (ctl.en[5]) begin
			act_s6  <= act_s5;
			oor_s6  <= oor_c;
			hd_s6   <= hd_c[15:0];
			srem_s6 <= srem_s5;
		end
	end

	// stages 7 to 9: align with the civil path
	logic        act_s7, oor_s7, act_s8, oor_s8, act_s9, oor_s9;
	logic [15:0] hd_s7, srem_s7, hd_s8, srem_s8, hd_s9, srem_s9;

	always_ff @(posedge clk) begin
		if (ctl.en[6]) begin
			act_s7  <= act_s6;
			oor_s7  <= oor_s6;
			hd_s7   <= hd_s6;
			srem_s7 <= srem_s6;
		end
		if (ctl.en[7]) begin
			act_s8  <= act_s7;
			oor_s8  <= oor_s7;
			hd_s8   <= hd_s7;
			srem_s8 <= srem_s7;
		end
		if (ctl.en[8]) begin
			act_s9  <= act_s8;
			oor_s9  <= oor_s8;
			hd_s9   <= hd_s8;
			srem_s9 <= srem_s8;
		end
	end

	assign halfday_out  = act_s9 ? hd_s9 : 16'd0;
	assign seconds_out  = act_s9 ? srem_s9 : 16'd0;
	assign out_of_range = act_s9 && oor_s9;

endmodule

`default_nettype wire

// ===== rtl/etcc_to_civil.sv =====
// Half-day stamp to civil date and time datapath (op 1), nine register stages.
// Depends on etcc_pkg; stage enables come from etcc_ctrl.
`default_nettype none

module etcc_to_civil import etcc_pkg::*; (
	input  logic        clk,
	input  pipe_ctrl_t  ctl,
	input  logic        op,
	input  logic [15:0] halfday_in,
	input  logic [15:0] seconds_in,
	output logic [11:0] year_out,
	output logic [3:0]  month_out,
	output logic [4:0]  day_out,
	output logic [4:0]  hour_out,
	output logic [5:0]  minute_out,
	output logic [5:0]  second_out
);

	// stage 1: seconds in the day, carry into the day count
	logic [16:0] total_c, tod_c;
	logic        dplus_c;

	logic        act_s1, dplus_s1;
	logic [14:0] hdh_s1;
	logic [16:0] tod_s1;

	always_comb begin
		total_c = {1'b0, seconds_in} + (halfday_in[0] ? 17'(HALFDAY_SECS) : 17'd0);
		dplus_c = total_c >= 17'(FULL_DAY);
		tod_c   = dplus_c ? total_c - 17'(FULL_DAY) : total_c;
	end

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			act_s1   <= (op == OP_TO_CIVIL);
			dplus_s1 <= dplus_c;
			hdh_s1   <= halfday_in[15:1];
			tod_s1   <= tod_c;
		end
	end

	// stage 2: era (4 or 5) and day of era; hour product
	logic [15:0] days_c;
	logic        era5_c;
	logic [17:0] doe_c;
	logic [34:0] ph_c;

	logic        act_s2, era5_s2;
	logic [17:0] doe_s2;
	logic [16:0] tod_s2;
	logic [34:0] ph_s2;

	always_comb begin
		days_c = {1'b0, hdh_s1} + {15'b0, dplus_s1};
		era5_c = days_c >= 16'(ERA5_START);
		doe_c  = era5_c ? {2'b0, days_c} - 18'(ERA5_START) : {2'b0, days_c} + 18'(ERA4_OFS);
		ph_c   = {18'b0, tod_s1} * {17'b0, D3600_M};
	end

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			act_s2  <= act_s1;
			era5_s2 <= era5_c;
			doe_s2  <= doe_c;
			tod_s2  <= tod_s1;
			ph_s2   <= ph_c;
		end
	end

	// stage 3: leap corrections of the day of era; hour and remainder
	logic [36:0] p1460_c, p36524_c;
	logic [4:0]  hour_c;
	logic [16:0] rem_c;

	logic        act_s3, era5_s3, c146_s3;
	logic [17:0] doe_s3;
	logic [6:0]  q1460_s3;
	logic [2:0]  q36524_s3;
	logic [4:0]  hour_s3;
	logic [11:0] rem_s3;

	always_comb begin
		p1460_c  = {19'b0, doe_s2} * {18'b0, D1460_M};
		p36524_c = {19'b0, doe_s2} * {18'b0, D36524_M};
		hour_c   = ph_s2[D3600_K+4:D3600_K];
		rem_c    = tod_s2 - {12'b0, hour_c} * 17'd3600;
	end

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			act_s3    <= act_s2;
			era5_s3   <= era5_s2;
			c146_s3   <= doe_s2 == 18'(ERA_DAYS - 1);
			doe_s3    <= doe_s2;
			q1460_s3  <= p1460_c[D1460_K+6:D1460_K];
			q36524_s3 <= p36524_c[D36524_K+2:D36524_K];
			hour_s3   <= hour_c;
			rem_s3    <= rem_c[11:0];
		end
	end

	// stage 4: numerator of the year of era; minute product
	logic [24:0] pm_c;

	logic        act_s4, era5_s4;
	logic [17:0] doe_s4, num_s4;
	logic [4:0]  hour_s4;
	logic [11:0] rem_s4;
	logic [5:0]  min_s4;

	always_comb begin
		pm_c = {13'b0, rem_s3} * {12'b0, D60_M};
	end

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			act_s4  <= act_s3;
			era5_s4 <= era5_s3;
			doe_s4  <= doe_s3;
			num_s4  <= doe_s3 - {11'b0, q1460_s3} + {15'b0, q36524_s3} - {17'b0, c146_s3};
			hour_s4 <= hour_s3;
			rem_s4  <= rem_s3;
			min_s4  <= pm_c[D60_K+5:D60_K];
		end
	end

	// stage 5: year of era; seconds
	logic [36:0] p365_c;
	logic [11:0] sec_c;

	logic        act_s5, era5_s5;
	logic [17:0] doe_s5;
	logic [8:0]  yoe_s5;
	logic [4:0]  hour_s5;
	logic [5:0]  min_s5, sec_s5;

	always_comb begin
		p365_c = {19'b0, num_s4} * {18'b0, D365_M};
		sec_c  = rem_s4 - {6'b0, min_s4} * 12'd60;
	end

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			act_s5  <= act_s4;
			era5_s5 <= era5_s4;
			doe_s5  <= doe_s4;
			yoe_s5  <= p365_c[D365_K+8:D365_K];
			hour_s5 <= hour_s4;
			min_s5  <= min_s4;
			sec_s5  <= sec_c[5:0];
		end
	end

	// stage 6: days in the whole years of the era
	logic [18:0] p100_c;

	logic        act_s6, era5_s6;
	logic [17:0] doe_s6, y365_s6;
	logic [8:0]  yoe_s6;
	logic [1:0]  y100_s6;
	logic [4:0]  hour_s6;
	logic [5:0]  min_s6, sec_s6;

	always_comb begin
		p100_c = {10'b0, yoe_s5} * {9'b0, D100_M};
	end

	always_ff @(posedge clk) begin
		if (ctl.en[5]) begin
			act_s6  <= act_s5;
			era5_s6 <= era5_s5;
			doe_s6  <= doe_s5;
			y365_s6 <= {9'b0, yoe_s5} * 18'd365;
			yoe_s6  <= yoe_s5;
			y100_s6 <= p100_c[D100_K+1:D100_K];
			hour_s6 <= hour_s5;
			min_s6  <= min_s5;
			sec_s6  <= sec_s5;
		end
	end

	// stage 7: day of year (March-based)
	logic [17:0] doy_c;

	logic        act_s7, era5_s7;
	logic [8:0]  doy_s7, yoe_s7;
	logic [4:0]  hour_s7;
	logic [5:0]  min_s7, sec_s7;

	always_comb begin
		doy_c = doe_s6 - (y365_s6 + {11'b0, yoe_s6[8:2]} - {16'b0, y100_s6});
	end

	always_ff @(posedge clk) begin
		if (ctl.en[6]) begin
			act_s7  <= act_s6;
			era5_s7 <= era5_s6;
			doy_s7  <= doy_c[8:0];
			yoe_s7  <= yoe_s6;
			hour_s7 <= hour_s6;
			min_s7  <= min_s6;
			sec_s7  <= sec_s6;
		end
	end

	// stage 8: month index
	logic [23:0] pmp_c;

	logic        act_s8, era5_s8;
	logic [8:0]  doy_s8, yoe_s8;
	logic [3:0]  mp_s8;
	logic [4:0]  hour_s8;
	logic [5:0]  min_s8, sec_s8;

	always_comb begin
		pmp_c = {15'b0, doy_s7} * {9'b0, D153_M5} + {11'b0, D153_M2};
	end

	always_ff @(posedge clk) begin
		if (ctl.en[7]) begin
			act_s8  <= act_s7;
			era5_s8 <= era5_s7;
			doy_s8  <= doy_s7;
			yoe_s8  <= yoe_s7;
			mp_s8   <= pmp_c[D153_K+3:D153_K];
			hour_s8 <= hour_s7;
			min_s8  <= min_s7;
			sec_s8  <= sec_s7;
		end
	end

	// stage 9: day, month and year
	logic [8:0]  dom_c;
	logic        janfeb_c;

	logic        act_s9;
	logic [11:0] year_s9;
	logic [3:0]  month_s9;
	logic [4:0]  day_s9, hour_s9;
	logic [5:0]  min_s9, sec_s9;

	always_comb begin
		dom_c    = doy_s8 - month_off(mp_s8) + 9'd1;
		janfeb_c = mp_s8 >= 4'd10;
	end

	always_ff @(posedge clk) begin
		if (ctl.en[8]) begin
			act_s9   <= act_s8;
			year_s9  <= {3'b0, yoe_s8} + (era5_s8 ? 12'd2000 : 12'd1600) + {11'b0, janfeb_c};
			month_s9 <= janfeb_c ? mp_s8 - 4'd9 : mp_s8 + 4'd3;
			day_s9   <= dom_c[4:0];
			hour_s9  <= hour_s8;
			min_s9   <= min_s8;
			sec_s9   <= sec_s8;
		end
	end

	assign year_out   = act_s9 ? year_s9 : 12'd0;
	assign month_out  = act_s9 ? month_s9 : 4'd0;
	assign day_out    = act_s9 ? day_s9 : 5'd0;
	assign hour_out   = act_s9 ? hour_s9 : 5'd0;
	assign minute_out = act_s9 ? min_s9 : 6'd0;
	assign second_out = act_s9 ? sec_s9 : 6'd0;

endmodule

`default_nettype wire

// ===== rtl/event_timestamp_civil_converter_top.sv =====
// Timestamp / civil date converter, top level. Uses etcc_pkg, etcc_if, etcc_ctrl,
// etcc_to_stamp and etcc_to_civil.
// Each accepted transaction passes through nine register stages before its result is on rsp.
// Throughput: one transaction per cycle; stalled stages hold, empty stages keep filling.
// Reset: arst_n clears only the stage valid bits; datapath registers are not reset.
`default_nettype none

module event_timestamp_civil_converter_top import etcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	etcc_cmd_if.sink   cmd,
	etcc_rsp_if.source rsp
);

	pipe_ctrl_t ctl;

	etcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.out_ready (rsp.ready),
		.in_ready  (cmd.ready),
		.ctl       (ctl)
	);

	etcc_to_stamp u_to_stamp (
		.clk          (clk),
		.ctl          (ctl),
		.op           (cmd.op),
		.year         (cmd.year),
		.month        (cmd.month),
		.day          (cmd.day),
		.hour         (cmd.hour),
		.minute       (cmd.minute),
		.second       (cmd.second),
		.halfday_out  (rsp.halfday_out),
		.seconds_out  (rsp.seconds_out),
		.out_of_range (rsp.out_of_range)
	);

	etcc_to_civil u_to_civil (
		.clk        (clk),
		.ctl        (ctl),
		.op         (cmd.op),
		.halfday_in (cmd.halfday_in),
		.seconds_in (cmd.seconds_in),
		.year_out   (rsp.year_out),
		.month_out  (rsp.month_out),
		.day_out    (rsp.day_out),
		.hour_out   (rsp.hour_out),
		.minute_out (rsp.minute_out),
		.second_out (rsp.second_out)
	);

	assign rsp.valid = ctl.vld[NST-1];

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for event_timestamp_civil_converter_top.
// Depends on etcc_pkg, etcc_if and the converter RTL; drives cmd and checks rsp against a
// built-in date/stamp predictor.

module testbench;
	import etcc_pkg::*;

	typedef struct packed {
		conv_op_t    op;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [15:0] halfday_in;
		logic [15:0] seconds_in;
	} conv_req_t;

	typedef struct packed {
		logic [15:0] halfday_out;
		logic [15:0] seconds_out;
		logic [11:0] year_out;
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic [4:0]  hour_out;
		logic [5:0]  minute_out;
		logic [5:0]  second_out;
		logic        out_of_range;
	} conv_res_t;

	localparam longint SHIFT_DAYS   = 719468;
	localparam longint ERA_LEN      = 146097;
	localparam longint HALFDAY_SECS_L = 12 * 60 * 60;
	localparam longint DAY_S        = 86400;
	localparam int     PIPE_LAT     = 9;
	localparam int     ITEMS_PHASE  = 310;
	localparam int     LIMIT_CYCLES = 300000;

	logic clk;
	logic arst_n;

	etcc_cmd_if cmd_if();
	etcc_rsp_if rsp_if();

	event_timestamp_civil_converter_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_if),
		.rsp   (rsp_if)
	);

	conv_req_t pending_conv_q[$];
	conv_res_t predicted_q[$];

	int  send_idle_pct = 0;
	int  stall_pct = 0;
	bit  cmd_taken = 0;
	int  cycle_cnt = 0;
	int  mismatches = 0;
	int  n_checked = 0;
	int  n_to_stamp = 0;
	int  n_to_civil = 0;
	int  n_flagged = 0;

	// Day number relative to 1970-01-01 of a proleptic Gregorian date; month and day may be
	// out of their usual ranges and simply shift the result.
	function automatic longint civil_day_number(longint y, longint m, longint d);
		longint era, yoe, mp, doy, doe;
		if (m <= 2) begin
			y = y - 1;
		end
		era = (y >= 0 ? y : y - 399) / 400;
		yoe = y - era * 400;
		mp = (m > 2) ? m - 3 : m + 9;
		doy = (153 * mp + 2) / 5 + d - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * ERA_LEN + doe - SHIFT_DAYS;
	endfunction

	function automatic conv_res_t predict_conversion(conv_req_t r);
		conv_res_t res;
		longint base_day, days, sod, hd, total, z, era, doe, yoe, doy, mp, mo;
		res = '0;
		base_day = civil_day_number(1977, 1, 1);
		if (r.op == OP_TO_STAMP) begin
			days = civil_day_number(longint'(r.year), longint'(r.month), longint'(r.day))
				- base_day;
			sod = longint'(r.hour) * 3600 + longint'(r.minute) * 60 + longint'(r.second);
			hd = days * 2 + sod / HALFDAY_SECS_L;
			res.halfday_out = hd[15:0];
			res.seconds_out = 16'(sod % HALFDAY_SECS_L);
			res.out_of_range = (days < 0) || (hd < 0) || (hd > 65535);
		end else begin
			total = longint'(r.seconds_in) + (r.halfday_in[0] ? HALFDAY_SECS_L : 64'sd0);
			days = longint'(r.halfday_in >> 1) + total / DAY_S;
			total = total % DAY_S;
			z = base_day + days + SHIFT_DAYS;
			era = z / ERA_LEN;
			doe = z - era * ERA_LEN;
			yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
			doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
			mp = (5 * doy + 2) / 153;
			mo = (mp < 10) ? mp + 3 : mp - 9;
			res.day_out = 5'(doy - (153 * mp + 2) / 5 + 1);
			res.month_out = 4'(mo);
			res.year_out = 12'(yoe + era * 400 + ((mo <= 2) ? 1 : 0));
			res.hour_out = 5'(total / 3600);
			res.minute_out = 6'((total / 60) % 60);
			res.second_out = 6'(total % 60);
		end
		return res;
	endfunction

	task automatic push_civil(int y, int m, int d, int h, int mi, int s);
		conv_req_t r;
		r = '0;
		r.op = OP_TO_STAMP;
		r.year = 12'(y);
		r.month = 4'(m);
		r.day = 5'(d);
		r.hour = 5'(h);
		r.minute = 6'(mi);
		r.second = 6'(s);
		pending_conv_q.insert(pending_conv_q.size(), r);
	endtask

	task automatic push_stamp(int hd, int secs);
		conv_req_t r;
		r = '0;
		r.op = OP_TO_CIVIL;
		r.halfday_in = 16'(hd);
		r.seconds_in = 16'(secs);
		pending_conv_q.insert(pending_conv_q.size(), r);
	endtask

	// Mostly plausible dates and stamps; one in five fills every field at full width.
	task automatic push_random_conv();
		conv_req_t r;
		bit wild;
		r = conv_req_t'($bits(conv_req_t)'({$urandom, $urandom, $urandom}));
		wild = ($urandom_range(4) == 0);
		if (!wild) begin
			if (r.op == OP_TO_STAMP) begin
				r.year = 12'($urandom_range(2068, 1976));
				r.month = 4'($urandom_range(12, 1));
				r.day = 5'($urandom_range(31, 1));
				r.hour = 5'($urandom_range(23));
				r.minute = 6'($urandom_range(59));
				r.second = 6'($urandom_range(60));
			end else begin
				r.seconds_in = 16'($urandom_range(43199));
			end
		end
		pending_conv_q.insert(pending_conv_q.size(), r);
	endtask

	task automatic wait_drained();
		while (pending_conv_q.size() != 0 || cmd_if.valid || predicted_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	initial begin
		cmd_if.valid = 1'b0;
		cmd_if.op = 1'b0;
		cmd_if.year = '0;
		cmd_if.month = '0;
		cmd_if.day = '0;
		cmd_if.hour = '0;
		cmd_if.minute = '0;
		cmd_if.second = '0;
		cmd_if.halfday_in = '0;
		cmd_if.seconds_in = '0;
		rsp_if.ready = 1'b0;
	end

	// Driver: a new transaction only once the current one has been taken.
	always @(negedge clk) begin
		conv_req_t nxt;
		bit go;
		if (arst_n) begin
			if (!cmd_if.valid || cmd_taken) begin
				go = (pending_conv_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
				if (go) begin
					nxt = pending_conv_q.pop_front();
					cmd_if.valid <= 1'b1;
					cmd_if.op <= nxt.op;
					cmd_if.year <= nxt.year;
					cmd_if.month <= nxt.month;
					cmd_if.day <= nxt.day;
					cmd_if.hour <= nxt.hour;
					cmd_if.minute <= nxt.minute;
					cmd_if.second <= nxt.second;
					cmd_if.halfday_in <= nxt.halfday_in;
					cmd_if.seconds_in <= nxt.seconds_in;
				end else begin
					cmd_if.valid <= 1'b0;
				end
			end
			rsp_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Monitor: predicts on cmd acceptance, checks on rsp acceptance.
	always @(posedge clk) begin
		conv_req_t seen_req;
		conv_res_t seen_res, want;
		cycle_cnt <= cycle_cnt + 1;
		cmd_taken <= cmd_if.valid && cmd_if.ready;
		if (arst_n) begin
			if (cmd_if.valid && cmd_if.ready) begin
				seen_req.op = conv_op_t'(cmd_if.op);
				seen_req.year = cmd_if.year;
				seen_req.month = cmd_if.month;
				seen_req.day = cmd_if.day;
				seen_req.hour = cmd_if.hour;
				seen_req.minute = cmd_if.minute;
				seen_req.second = cmd_if.second;
				seen_req.halfday_in = cmd_if.halfday_in;
				seen_req.seconds_in = cmd_if.seconds_in;
				want = predict_conversion(seen_req);
				predicted_q.insert(predicted_q.size(), want);
				if (seen_req.op == OP_TO_STAMP) begin
					n_to_stamp <= n_to_stamp + 1;
				end else begin
					n_to_civil <= n_to_civil + 1;
				end
				if (want.out_of_range) begin
					n_flagged <= n_flagged + 1;
				end
			end
			if (rsp_if.valid && rsp_if.ready) begin
				seen_res.halfday_out = rsp_if.halfday_out;
				seen_res.seconds_out = rsp_if.seconds_out;
				seen_res.year_out = rsp_if.year_out;
				seen_res.month_out = rsp_if.month_out;
				seen_res.day_out = rsp_if.day_out;
				seen_res.hour_out = rsp_if.hour_out;
				seen_res.minute_out = rsp_if.minute_out;
				seen_res.second_out = rsp_if.second_out;
				seen_res.out_of_range = rsp_if.out_of_range;
				if (predicted_q.size() == 0) begin
					if (mismatches < 10) begin
						$display("%0t: unexpected rsp transaction %p", $realtime, seen_res);
					end
					mismatches <= mismatches + 1;
				end else begin
					want = predicted_q.pop_front();
					n_checked <= n_checked + 1;
					if (seen_res.halfday_out !== want.halfday_out
						|| seen_res.seconds_out !== want.seconds_out
						|| seen_res.year_out !== want.year_out
						|| seen_res.month_out !== want.month_out
						|| seen_res.day_out !== want.day_out
						|| seen_res.hour_out !== want.hour_out
						|| seen_res.minute_out !== want.minute_out
						|| seen_res.second_out !== want.second_out
						|| seen_res.out_of_range !== want.out_of_range) begin
						if (mismatches < 10) begin
							$display("%0t: rsp mismatch\n  expected %p\n  actual   %p",
								$realtime, want, seen_res);
						end
						mismatches <= mismatches + 1;
					end
				end
			end
		end
		if (cycle_cnt == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, predicted_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int phase_send[4];
		int phase_stall[4];
		phase_send = '{0, 88, 0, 10};
		phase_stall = '{0, 0, 88, 10};
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: base date, range edges, odd months/days, leap second, carries.
		push_civil(1977, 1, 1, 0, 0, 0);
		push_civil(1976, 12, 31, 23, 59, 59);
		push_civil(1977, 1, 1, 12, 0, 0);
		push_civil(1977, 1, 1, 23, 59, 60);
		push_civil(2000, 2, 29, 11, 59, 59);
		push_civil(2066, 9, 18, 23, 59, 59);
		push_civil(2066, 9, 19, 0, 0, 0);
		push_civil(0, 1, 1, 0, 0, 0);
		push_civil(0, 0, 0, 0, 0, 0);
		push_civil(4095, 15, 31, 31, 63, 63);
		push_civil(1999, 0, 1, 6, 30, 0);
		push_civil(1999, 13, 1, 6, 30, 0);
		push_civil(2010, 3, 0, 0, 0, 1);
		push_civil(2010, 5, 10, 31, 63, 63);
		push_civil(2067, 1, 1, 0, 0, 0);
		push_stamp(0, 0);
		push_stamp(1, 43199);
		push_stamp(0, 65535);
		push_stamp(1, 65535);
		push_stamp(65535, 65535);
		push_stamp(65534, 0);
		push_stamp(65535, 0);
		wait_drained();

		// Draining between modes also makes the sender sit idle until all results are back.
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = phase_send[p];
			stall_pct = phase_stall[p];
			repeat (ITEMS_PHASE) push_random_conv();
			wait_drained();
		end
		stall_pct = 0;

		repeat (2 * PIPE_LAT + 2) @(posedge clk);
		$display("Covered %0d conversions: %0d date-to-stamp (%0d beyond range), %0d stamp-to-date,",
			n_checked, n_to_stamp, n_flagged, n_to_civil);
		$display("under free-running, sparse-sender, stalled-receiver and mixed pacing.");
		if (mismatches == 0 && predicted_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/etcc_pkg.sv
rtl/etcc_if.sv
rtl/etcc_ctrl.sv
rtl/etcc_to_stamp.sv
rtl/etcc_to_civil.sv
rtl/event_timestamp_civil_converter_top.sv
test/testbench.sv
